// ----- hdl/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg: shared constants of the direct-mapped read cache
// Field widths, default geometry and the reset value of the miss penalty.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Fixed field widths
  localparam int ADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;
  localparam int PEN_W  = 8;

  // Default geometry
  localparam int DEF_NUM_LINES  = 8;
  localparam int DEF_LINE_BYTES = 16;
  localparam int DEF_MEM_BYTES  = 4096;

  // Reset value of the miss penalty register
  localparam logic [PEN_W-1:0] PENALTY_RST = PEN_W'(10);

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

endpackage

// ----- hdl/dmc_ram.sv -----
// ----------------------------------------------------------------------------
// dmc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/direct_mapped_cache_read.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_cache_read: direct-mapped read-only byte cache
// Byte-wide backing memory behind a direct-mapped line store, with time,
// miss and access statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per command.
//   A load command (command_i = 0) writes write_data_i into the backing
//   memory; it never touches cached lines, so lines may go stale.
//   A read command (command_i = 1) looks up the line picked by the address,
//   refills it byte by byte from the backing memory on a miss, and returns
//   the addressed byte, the hit flag and the running counters.
//   Output channel (out_valid_o / out_stall_i) delivers one beat per command.
//   A miss refills the line through the single read port of the backing
//   memory, one byte per cycle. All counter updates share one 32-bit
//   saturating adder, one update per sequencer step.
//   Reset clears valid bits, counters and control, and loads a miss penalty
//   of 10. Backing memory and line data hold nothing until written.
//   A stalled result sits in the output register; the next command is still
//   accepted and waits in its final step until the output register frees.
//   The miss penalty port takes a write in any cycle; write it only while
//   no command is in flight.
// ----------------------------------------------------------------------------
module direct_mapped_cache_read #(
  parameter int NUM_LINES  = dmc_pkg::DEF_NUM_LINES,
  parameter int LINE_BYTES = dmc_pkg::DEF_LINE_BYTES,
  parameter int MEM_BYTES  = dmc_pkg::DEF_MEM_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dmc_pkg::PEN_W-1:0]   miss_penalty_i,
  // command input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [dmc_pkg::ADDR_W-1:0]  address_i,
  input  logic [dmc_pkg::BYTE_W-1:0]  write_data_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dmc_pkg::BYTE_W-1:0]  read_data_o,
  output logic                        hit_o,
  output logic [dmc_pkg::CNT_W-1:0]   total_time_o,
  output logic [dmc_pkg::CNT_W-1:0]   miss_count_o,
  output logic [dmc_pkg::CNT_W-1:0]   access_count_o
);

  import dmc_pkg::*;

  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(NUM_LINES);
  localparam int TAG_W  = MEM_AW - OFF_W - IDX_W;
  localparam int LAW    = IDX_W + OFF_W;
  localparam int FCW    = OFF_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIME,
    S_MISS,
    S_PEN,
    S_FILL,
    S_ACC,
    S_DONE
  } state_e;

  state_e state_q;

  // Control and statistics
  logic [NUM_LINES-1:0] line_valid_q;
  logic [PEN_W-1:0]     penalty_q;
  logic [CNT_W-1:0]     time_q, miss_q, acc_q;
  logic [FCW-1:0]       fill_cnt_q;
  logic                 out_valid_q;

  // Payload
  logic [TAG_W-1:0]  line_tag_q [NUM_LINES];
  logic [TAG_W-1:0]  req_tag_q;
  logic [IDX_W-1:0]  req_idx_q;
  logic [OFF_W-1:0]  req_off_q;
  logic [BYTE_W-1:0] data_q;
  logic              hit_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_hit_q;
  logic [CNT_W-1:0]  out_time_q, out_miss_q, out_acc_q;

  // Address split of the incoming beat
  logic [MEM_AW-1:0] in_addr;
  logic [OFF_W-1:0]  in_off;
  logic [IDX_W-1:0]  in_idx;
  logic [TAG_W-1:0]  in_tag;

  assign in_addr = MEM_AW'(address_i);
  assign in_off  = in_addr[OFF_W-1:0];
  assign in_idx  = in_addr[OFF_W +: IDX_W];
  assign in_tag  = in_addr[MEM_AW-1 -: TAG_W];

  logic in_accept, out_take, out_free;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_take  = out_valid_q && !out_stall_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Shared saturating adder: one counter update per sequencer step
  logic [CNT_W-1:0] add_a, add_b, add_res;
  logic [CNT_W:0]   add_sum;

  always_comb begin
    case (state_q)
      S_MISS: begin
        add_a = miss_q;
        add_b = CNT_W'(1);
      end
      S_PEN: begin
        add_a = time_q;
        add_b = CNT_W'(penalty_q);
      end
      S_ACC: begin
        add_a = acc_q;
        add_b = CNT_W'(1);
      end
      default: begin
        add_a = time_q;
        add_b = CNT_W'(1);
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign add_res = add_sum[CNT_W] ? {CNT_W{1'b1}} : add_sum[CNT_W-1:0];

  // Tag compare against the latched request
  logic hit_now;
  assign hit_now = line_valid_q[req_idx_q] && (line_tag_q[req_idx_q] == req_tag_q);

  // Refill bookkeeping
  logic [FCW-1:0]   fill_prev;
  logic             fill_wr, fill_last;
  assign fill_prev = fill_cnt_q - FCW'(1);
  assign fill_wr   = (state_q == S_FILL) && (fill_cnt_q != '0);
  assign fill_last = (fill_cnt_q == FCW'(LINE_BYTES));

  // Backing memory: written by load beats, read during refill
  logic              mem_we;
  logic [MEM_AW-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  assign mem_we    = in_accept && (command_i == CMD_LOAD);
  assign mem_raddr = {req_tag_q, req_idx_q, fill_cnt_q[OFF_W-1:0]};

  dmc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_BYTES)
  ) u_backing (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_addr),
    .wdata_i (write_data_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Line store: read at the incoming address, written during refill
  logic [LAW-1:0]    line_waddr, line_raddr;
  logic [BYTE_W-1:0] line_rdata;

  assign line_waddr = {req_idx_q, fill_prev[OFF_W-1:0]};
  assign line_raddr = {in_idx, in_off};

  dmc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NUM_LINES * LINE_BYTES)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (fill_wr),
    .waddr_i (line_waddr),
    .wdata_i (mem_rdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  // Sequencer, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      line_valid_q <= '0;
      penalty_q    <= PENALTY_RST;
      time_q       <= '0;
      miss_q       <= '0;
      acc_q        <= '0;
      fill_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        penalty_q <= miss_penalty_i;
      end
      // Drop the taken beat unless the final step refills the register now
      if (out_take && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= (command_i == CMD_READ) ? S_TIME : S_DONE;
          end
        end
        S_TIME: begin
          time_q  <= add_res;
          state_q <= hit_now ? S_ACC : S_MISS;
        end
        S_MISS: begin
          miss_q  <= add_res;
          state_q <= S_PEN;
        end
        S_PEN: begin
          time_q     <= add_res;
          fill_cnt_q <= '0;
          state_q    <= S_FILL;
        end
        S_FILL: begin
          if (fill_last) begin
            line_valid_q[req_idx_q] <= 1'b1;
            state_q                 <= S_ACC;
          end else begin
            fill_cnt_q <= fill_cnt_q + FCW'(1);
          end
        end
        S_ACC: begin
          acc_q   <= add_res;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request, line tags and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_tag_q <= in_tag;
      req_idx_q <= in_idx;
      req_off_q <= in_off;
      data_q    <= '0;
      hit_q     <= 1'b0;
    end
    if (state_q == S_TIME) begin
      hit_q <= hit_now;
      if (hit_now) begin
        data_q <= line_rdata;
      end
    end
    // Grab the requested byte as it streams past during refill
    if (fill_wr && (fill_prev[OFF_W-1:0] == req_off_q)) begin
      data_q <= mem_rdata;
    end
    if ((state_q == S_FILL) && fill_last) begin
      line_tag_q[req_idx_q] <= req_tag_q;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_data_q <= data_q;
      out_hit_q  <= hit_q;
      out_time_q <= time_q;
      out_miss_q <= miss_q;
      out_acc_q  <= acc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_data_q;
  assign hit_o          = out_hit_q;
  assign total_time_o   = out_time_q;
  assign miss_count_o   = out_miss_q;
  assign access_count_o = out_acc_q;

`ifndef ASSERT_OFF
  // Misses never outnumber accesses in a reported result
  a_miss_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (miss_count_o <= access_count_o))
    else $error("miss count above access count");

  // Running time is at least one unit per access
  a_time_ge_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (total_time_o >= access_count_o))
    else $error("total time below access count");

  // A load beat leaves the time counter alone
  a_load_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (command_i == CMD_LOAD)) |=> $stable(time_q))
    else $error("load changed time counter");

  // A finished refill leaves its line valid
  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FILL) && fill_last) |=> line_valid_q[req_idx_q])
    else $error("refilled line not valid");
`endif

endmodule

// ----- tb/direct_mapped_cache_read_tb.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_cache_read_tb: self-checking bench for the direct-mapped cache
// Loads and cached reads go in through a random-idle driver. A local cache
// image predicts every result beat, and a random-stall monitor compares each
// beat field by field. The miss penalty is reprogrammed between phases.
// ----------------------------------------------------------------------------
module direct_mapped_cache_read_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  // Address split for the default geometry
  localparam int OFF_W      = $clog2(DEF_LINE_BYTES);
  localparam int IDX_W      = $clog2(DEF_NUM_LINES);
  localparam int BLK_W      = ADDR_W - OFF_W;
  localparam int TAG_W      = BLK_W - IDX_W;
  localparam int NUM_BLOCKS = DEF_MEM_BYTES / DEF_LINE_BYTES;

  localparam int IDLE_PCT       = 29;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } cache_op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rdata;
    logic              hit;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  misses;
    logic [CNT_W-1:0]  accesses;
  } cache_resp_t;

  // DUT ports
  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [PEN_W-1:0]  miss_penalty_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              command_i;
  logic [ADDR_W-1:0] address_i;
  logic [BYTE_W-1:0] write_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] read_data_o;
  logic              hit_o;
  logic [CNT_W-1:0]  total_time_o;
  logic [CNT_W-1:0]  miss_count_o;
  logic [CNT_W-1:0]  access_count_o;

  // Bench bookkeeping
  cache_op_t   cmd_queue[$];   // commands not yet driven
  cache_resp_t due_results[$]; // predicted result beats, oldest first
  int          n_queued;
  int          n_accepted;
  int          err_count;
  int          idle_cycles;
  bit          in_taken;       // current input beat was accepted at the last edge
  bit          cfg_done;       // penalty write accepted
  bit          steady;         // no idling on either side while set

  // Generator view: which blocks are fully loaded and safe to read
  bit          block_loaded[NUM_BLOCKS];
  logic [BLK_W-1:0] loaded_list[$];
  logic [BLK_W-1:0] last_blk;

  // Cache image used for prediction
  logic [BYTE_W-1:0] mem_image [DEF_MEM_BYTES];
  logic              line_ok   [DEF_NUM_LINES];
  logic [TAG_W-1:0]  line_tag_q[DEF_NUM_LINES];
  logic [BYTE_W-1:0] line_data [DEF_NUM_LINES][DEF_LINE_BYTES];
  logic [CNT_W-1:0]  run_time;
  logic [CNT_W-1:0]  miss_total;
  logic [CNT_W-1:0]  access_total;
  logic [PEN_W-1:0]  penalty_q;

  direct_mapped_cache_read uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .miss_penalty_i (miss_penalty_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .hit_o          (hit_o),
    .total_time_o   (total_time_o),
    .miss_count_o   (miss_count_o),
    .access_count_o (access_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Saturating 32-bit add, as the counters stick at all ones
  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  // Apply one command to the cache image and return the result beat it causes
  function automatic cache_resp_t cache_access(cache_op_t op);
    cache_resp_t      r;
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tg;
    logic [BLK_W-1:0] blk;
    int               i;
    r = '0;
    {tg, idx, off} = op.addr;
    blk = op.addr[ADDR_W-1:OFF_W];
    if (op.cmd == CMD_LOAD) begin
      // Backing store only: a cached copy of this byte goes stale
      mem_image[op.addr] = op.data;
    end else begin
      run_time = sat_add(run_time, 1);
      if (line_ok[idx] && line_tag_q[idx] == tg) begin
        r.hit = 1'b1;
      end else begin
        miss_total = sat_add(miss_total, 1);
        run_time   = sat_add(run_time, CNT_W'(penalty_q));
        for (i = 0; i < DEF_LINE_BYTES; i++) begin
          line_data[idx][i] = mem_image[{blk, OFF_W'(i)}];
        end
        line_tag_q[idx] = tg;
        line_ok[idx]    = 1'b1;
      end
      access_total = sat_add(access_total, 1);
      r.rdata = line_data[idx][off];
    end
    r.total    = run_time;
    r.misses   = miss_total;
    r.accesses = access_total;
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Command generation. Reads only ever target blocks whose 16 bytes were all
  // loaded first, so a refill never pulls an unwritten backing byte.
  // ---------------------------------------------------------------------------
  task automatic push_load(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
    cache_op_t op;
    op.cmd  = CMD_LOAD;
    op.addr = addr;
    op.data = data;
    cmd_queue.push_back(op);
    n_queued++;
  endtask

  task automatic push_read(logic [ADDR_W-1:0] addr);
    cache_op_t op;
    op.cmd  = CMD_READ;
    op.addr = addr;
    op.data = BYTE_W'($urandom_range(255)); // don't-care byte, toggle it anyway
    cmd_queue.push_back(op);
    n_queued++;
    last_blk = addr[ADDR_W-1:OFF_W];
  endtask

  // Load a whole block with random bytes and mark it readable
  task automatic fill_block(logic [BLK_W-1:0] blk);
    int i;
    for (i = 0; i < DEF_LINE_BYTES; i++) begin
      push_load({blk, OFF_W'(i)}, BYTE_W'($urandom_range(255)));
    end
    if (!block_loaded[blk]) begin
      block_loaded[blk] = 1'b1;
      loaded_list.push_back(blk);
    end
  endtask

  // Random traffic: block fills, stray loads (stale lines), reads that half the
  // time revisit the last block (hits) and else jump to any loaded block (conflicts)
  task automatic gen_traffic(int count);
    int               stop_at;
    int               pick;
    logic [BLK_W-1:0] blk;
    stop_at = n_queued + count;
    while (n_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        fill_block(BLK_W'($urandom_range(NUM_BLOCKS - 1)));
      end else if (pick < 22) begin
        push_load(ADDR_W'($urandom_range(DEF_MEM_BYTES - 1)), BYTE_W'($urandom_range(255)));
      end else begin
        if ($urandom_range(1) == 0) begin
          blk = last_blk;
        end else begin
          blk = loaded_list[$urandom_range(loaded_list.size() - 1)];
        end
        push_read({blk, OFF_W'($urandom_range(DEF_LINE_BYTES - 1))});
      end
    end
  endtask

  // Hold until every queued beat went in and every result beat came out
  task automatic wait_idle();
    wait (n_accepted == n_queued && due_results.size() == 0);
  endtask

  task automatic program_penalty(logic [PEN_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_done = 1'b0;
    cfg_valid_i    <= 1'b1;
    miss_penalty_i <= value;
    do @(negedge clk_i); while (!cfg_done);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver and output stall, both changing on the falling edge.
  // Valid is chosen without looking at stall; an unaccepted beat holds.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_side
    cache_op_t op;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (cmd_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          op = cmd_queue.pop_front();
          in_valid_i   <= 1'b1;
          command_i    <= op.cmd;
          address_i    <= op.addr;
          write_data_i <= op.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Rising-edge sampling: predict accepted commands, check result beats,
  // apply penalty writes, and run the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_side
    cache_op_t   op;
    cache_resp_t got;
    cache_resp_t want;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        penalty_q = miss_penalty_i;
        cfg_done  = 1'b1;
        moved     = 1'b1;
      end

      if (in_valid_i && !in_stall_o) begin
        op.cmd  = command_i;
        op.addr = address_i;
        op.data = write_data_i;
        due_results.push_back(cache_access(op));
        in_taken = 1'b1;
        n_accepted++;
        moved = 1'b1;
      end

      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got.rdata    = read_data_o;
        got.hit      = hit_o;
        got.total    = total_time_o;
        got.misses   = miss_count_o;
        got.accesses = access_count_o;
        if (due_results.size() == 0) begin
          report_error("result beat with no command outstanding");
        end else begin
          want = due_results.pop_front();
          if (got.rdata !== want.rdata)
            report_error($sformatf("read_data %0h, want %0h", got.rdata, want.rdata));
          if (got.hit !== want.hit)
            report_error($sformatf("hit %0b, want %0b", got.hit, want.hit));
          if (got.total !== want.total)
            report_error($sformatf("total_time %0d, want %0d", got.total, want.total));
          if (got.misses !== want.misses)
            report_error($sformatf("miss_count %0d, want %0d", got.misses, want.misses));
          if (got.accesses !== want.accesses)
            report_error($sformatf("access_count %0d, want %0d",
                                   got.accesses, want.accesses));
        end
      end

      // Stop a hung run: count edges on which no beat moved anywhere
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a beat, %0d of %0d commands taken",
                 idle_cycles, n_accepted, n_queued);
        $display("direct_mapped_cache_read_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corner cases under the reset penalty, then
  // random phases under both extreme miss penalties and a random one.
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int i;
    // Drive every input to a known value from time zero
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    miss_penalty_i = '0;
    in_valid_i     = 1'b0;
    command_i      = CMD_LOAD;
    address_i      = '0;
    write_data_i   = '0;
    out_stall_i    = 1'b0;
    n_queued       = 0;
    n_accepted     = 0;
    err_count      = 0;
    idle_cycles    = 0;
    in_taken       = 1'b0;
    cfg_done       = 1'b0;
    steady         = 1'b0;
    last_blk       = '0;
    run_time       = '0;
    miss_total     = '0;
    access_total   = '0;
    penalty_q      = PENALTY_RST;
    for (i = 0; i < DEF_NUM_LINES; i++) line_ok[i] = 1'b0;
    for (i = 0; i < NUM_BLOCKS; i++) block_loaded[i] = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Prepare the corner blocks: lowest and highest address, and the two
    // extreme tags on the first and last line
    fill_block(BLK_W'(0));
    fill_block('1);
    fill_block({{TAG_W{1'b1}}, {IDX_W{1'b0}}});
    fill_block({{TAG_W{1'b0}}, {IDX_W{1'b1}}});

    // Directed part, reset penalty in force
    push_read(12'h000);                 // cold miss, offset zero
    push_read(12'h00F);                 // hit, top offset
    push_read(12'hFFF);                 // cold miss at the top address
    push_read(12'hFF0);                 // hit on the last line
    push_read(12'hF80);                 // conflict on line zero, evicts tag zero
    push_read(12'h005);                 // conflict back again
    push_load(12'h005, 8'hFF);          // backing byte changes under a live line
    push_load(12'h006, 8'h00);
    push_read(12'h005);                 // stale hit: old byte comes back
    push_read(12'h006);
    push_read(12'hF85);                 // evict the stale copy
    push_read(12'h005);                 // refill picks up the new bytes
    push_read(12'h006);
    push_read(12'h070);                 // tag zero on the last line
    push_read(12'h07F);
    push_read(12'hFFF);                 // same line, tag flip back
    push_load(12'hFFF, 8'h00);
    push_load(12'h000, 8'hFF);
    push_read(12'hFFF);                 // stale hit: old byte comes back
    push_read(12'h000);

    program_penalty(PEN_W'(0));
    gen_traffic(400);

    // Run one phase back to back on both sides
    program_penalty('1);
    wait_idle();
    steady = 1'b1;
    gen_traffic(400);
    wait_idle();
    steady = 1'b0;

    program_penalty(PEN_W'($urandom_range(1, 254)));
    gen_traffic(350);

    // Drain, then give stray beats time to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0)
      report_error($sformatf("%0d result beats never arrived", due_results.size()));

    if (err_count == 0) begin
      $display("direct_mapped_cache_read_tb OK");
    end else begin
      $display("direct_mapped_cache_read_tb NOT OK");
    end
    $finish;
  end

endmodule
